// ===== src/assert_macros.svh =====
// Assertion macros shared by the transcoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define UTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition that must never hold outside reset.
`define UTT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== src/utt_pkg.sv =====
// Types, constants and helpers shared by the UTF-8 to UTF-16 transcoder.
package utt_pkg;

    localparam int CODE_W  = 21;
    localparam int UNIT_W  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

    // Smallest legal value class of the sequence being gathered.
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_2B   = 2'd1;
    localparam logic [1:0] CLASS_3B   = 2'd2;
    localparam logic [1:0] CLASS_4B   = 2'd3;

    localparam logic [CODE_W-1:0] MIN_2B      = 21'h00080;
    localparam logic [CODE_W-1:0] MIN_3B      = 21'h00800;
    localparam logic [CODE_W-1:0] MIN_4B      = 21'h10000;
    localparam logic [CODE_W-1:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_FIRST  = 21'h0D800;
    localparam logic [CODE_W-1:0] SURR_LAST   = 21'h0DFFF;
    localparam logic [UNIT_W-1:0] HIGH_BASE   = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_BASE    = 16'hDC00;
    localparam logic [UNIT_W-1:0] TEN_MASK    = 16'h03FF;

    // One result item.
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              error;
        logic              last;
    } t_unit;

    // Up to two result items produced by one byte.
    typedef struct packed {
        logic [1:0] count;
        t_unit      first;
        t_unit      second;
    } t_res;

    function automatic logic [CODE_W-1:0] min_value(input logic [1:0] cls);
        logic [CODE_W-1:0] v;
        case (cls)
            CLASS_2B: v = MIN_2B;
            CLASS_3B: v = MIN_3B;
            CLASS_4B: v = MIN_4B;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/utt_decode.sv =====
// Byte decoder: sequence state, validity checks and UTF-16 unit generation.
`include "assert_macros.svh"

module utt_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_eos,
    output utt_pkg::t_res      o_res
);

    logic [1:0]                   r_pending, n_pending;
    logic [utt_pkg::CODE_W-1:0]   r_partial, n_partial;
    logic [1:0]                   r_class,   n_class;
    logic                         r_dropping, n_dropping;

    logic [utt_pkg::CODE_W-1:0]   cont_code;
    logic [utt_pkg::CODE_W-1:0]   cp;
    logic [utt_pkg::CODE_W-1:0]   supp;
    logic                         fail;
    logic                         emit;
    utt_pkg::t_res                res;

    assign cont_code = {r_partial[utt_pkg::CODE_W-7:0], i_byte[5:0]};
    assign supp      = cp - utt_pkg::MIN_4B;

    always_comb begin
        n_pending  = r_pending;
        n_partial  = r_partial;
        n_class    = r_class;
        n_dropping = r_dropping;
        res        = '0;
        fail       = 1'b0;
        emit       = 1'b0;
        cp         = '0;

        if (r_dropping) begin
            if (i_eos) begin
                res.count        = 2'd1;
                res.first.error  = 1'b1;
                res.first.last   = 1'b1;
                n_dropping       = 1'b0;
            end
        end else if (r_pending == 2'd0) begin
            if (!i_byte[7]) begin
                emit = 1'b1;
                cp   = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_pending = 2'd1;
                n_partial = {16'd0, i_byte[4:0]};
                n_class   = utt_pkg::CLASS_2B;
                fail      = i_eos;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_pending = 2'd2;
                n_partial = {17'd0, i_byte[3:0]};
                n_class   = utt_pkg::CLASS_3B;
                fail      = i_eos;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_pending = 2'd3;
                n_partial = {18'd0, i_byte[2:0]};
                n_class   = utt_pkg::CLASS_4B;
                fail      = i_eos;
            end else begin
                fail = 1'b1;
            end
        end else begin
            if (i_byte[7:6] != 2'b10) begin
                fail = 1'b1;
            end else if (r_pending != 2'd1) begin
                n_partial = cont_code;
                n_pending = r_pending - 2'd1;
                fail      = i_eos;
            end else if (cont_code < utt_pkg::min_value(r_class) ||
                         cont_code > utt_pkg::MAX_CODE ||
                         (cont_code >= utt_pkg::SURR_FIRST &&
                          cont_code <= utt_pkg::SURR_LAST)) begin
                fail = 1'b1;
            end else begin
                emit      = 1'b1;
                cp        = cont_code;
                n_pending = 2'd0;
                n_partial = '0;
                n_class   = utt_pkg::CLASS_NONE;
            end
        end

        // An error clears the sequence; at the string end it reports at once.
        if (fail) begin
            n_pending  = 2'd0;
            n_partial  = '0;
            n_class    = utt_pkg::CLASS_NONE;
            n_dropping = !i_eos;
            if (i_eos) begin
                res.count       = 2'd1;
                res.first.error = 1'b1;
                res.first.last  = 1'b1;
            end
        end

        if (emit) begin
            if (cp >= utt_pkg::MIN_4B) begin
                res.count       = 2'd2;
                res.first.unit  = utt_pkg::HIGH_BASE | {6'd0, supp[19:10]};
                res.second.unit = utt_pkg::LOW_BASE | {6'd0, supp[9:0]};
                res.second.last = i_eos;
            end else begin
                res.count       = 2'd1;
                res.first.unit  = cp[utt_pkg::UNIT_W-1:0];
                res.first.last  = i_eos;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 2'd0;
            r_partial  <= '0;
            r_class    <= utt_pkg::CLASS_NONE;
            r_dropping <= 1'b0;
        end else if (i_fire) begin
            r_pending  <= n_pending;
            r_partial  <= n_partial;
            r_class    <= n_class;
            r_dropping <= n_dropping;
        end
    end

    `UTT_ASSERT_IMPL(a_drop_clean, i_clk, i_rst_n, r_dropping, r_pending == 2'd0 && r_partial == '0)
    `UTT_ASSERT_IMPL(a_pair_is_surrogate, i_clk, i_rst_n, i_fire && res.count == 2'd2, !res.first.error && res.first.unit[15:10] == 6'b110110 && res.second.unit[15:10] == 6'b110111)

endmodule

// ===== src/utt_result_fifo.sv =====
// Small result queue that absorbs one or two items per cycle and drains one.
`include "assert_macros.svh"

module utt_result_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  utt_pkg::t_res             i_res,
    input  logic                      i_pop_ready,
    output logic                      o_valid,
    output utt_pkg::t_unit            o_head,
    output logic                      o_room_for_two
);

    utt_pkg::t_unit                r_slot [utt_pkg::FIFO_DEPTH];
    logic [utt_pkg::PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [utt_pkg::PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [utt_pkg::CNT_W-1:0]     r_count, n_count;
    logic [utt_pkg::CNT_W-1:0]     after_pop;
    logic [utt_pkg::CNT_W-1:0]     push_cnt;
    logic [utt_pkg::PTR_W-1:0]     wr_next;
    logic                          pop;

    assign pop       = o_valid && i_pop_ready;
    assign after_pop = r_count - {{(utt_pkg::CNT_W-1){1'b0}}, pop};
    assign push_cnt  = i_push ? {{(utt_pkg::CNT_W-2){1'b0}}, i_res.count}
                              : '0;
    assign n_count   = after_pop + push_cnt;
    assign wr_next   = r_wr_ptr + {{(utt_pkg::PTR_W-1){1'b0}}, 1'b1};
    assign n_wr_ptr  = r_wr_ptr + push_cnt[utt_pkg::PTR_W-1:0];
    assign n_rd_ptr  = r_rd_ptr + {{(utt_pkg::PTR_W-1){1'b0}}, pop};

    assign o_valid        = r_count != '0;
    assign o_head         = r_slot[r_rd_ptr];
    assign o_room_for_two = after_pop <= utt_pkg::CNT_W'(utt_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push && i_res.count != 2'd0) begin
            r_slot[r_wr_ptr] <= i_res.first;
        end
        if (i_push && i_res.count == 2'd2) begin
            r_slot[wr_next] <= i_res.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    `UTT_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, n_count > utt_pkg::CNT_W'(utt_pkg::FIFO_DEPTH))
    `UTT_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push && i_res.count != 2'd0, o_valid)

endmodule

// ===== src/utt_to_utf16_top_placeholder.sv =====
// Input register stage that holds one byte item for the decoder.
module utt_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_full,
    output logic [7:0] o_byte,
    output logic       o_eos
);

    logic       r_full;
    logic [7:0] r_byte;
    logic       r_eos;
    logic       load;

    assign o_ready = !r_full || i_advance;
    assign load    = i_valid && o_ready;
    assign o_full  = r_full;
    assign o_byte  = r_byte;
    assign o_eos   = r_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (load) begin
            r_full <= 1'b1;
        end else if (i_advance) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
            r_eos  <= i_eos;
        end
    end

endmodule

// ===== src/utf8_to_utf16_transcoder.sv =====
// An accepted byte is registered in the input stage, then decoded into the result queue.
// Throughput: one byte per cycle while the queue has room; a four-byte sequence adds one
// extra item, which the four-entry queue absorbs while the consumer keeps taking items.
// Input is held whenever the queue, after this cycle's drain, has fewer than two free slots.
// Reset (i_rst_n low, synchronous) empties both stages and clears the sequence state.
// No clearing pass is needed: the block accepts items in the first cycle after reset.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_unit_out,
    output logic        o_error,
    output logic        o_last
);

    // The input stage registers one byte item. It hands the item to the
    // decoder only when the result queue can take the worst case of two
    // result items, so nothing is ever lost on the output side.
    logic          stage_full;
    logic [7:0]    stage_byte;
    logic          stage_eos;
    logic          room_for_two;
    logic          advance;
    utt_pkg::t_res dec_res;
    utt_pkg::t_unit head;

    assign advance = stage_full && room_for_two;

    utt_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_byte    (i_byte_in),
        .i_eos     (i_end_of_string),
        .i_advance (advance),
        .o_ready   (o_ready),
        .o_full    (stage_full),
        .o_byte    (stage_byte),
        .o_eos     (stage_eos)
    );

    // The decoder updates the sequence state and produces zero, one or two
    // result items in the same cycle that the registered byte advances.
    utt_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (stage_byte),
        .i_eos   (stage_eos),
        .o_res   (dec_res)
    );

    // The result queue parts the decoder from the consumer, so a stalled
    // consumer does not stop byte intake until the queue is nearly full.
    utt_result_fifo u_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (advance),
        .i_res          (dec_res),
        .i_pop_ready    (i_ready),
        .o_valid        (o_valid),
        .o_head         (head),
        .o_room_for_two (room_for_two)
    );

    assign o_unit_out = head.unit;
    assign o_error    = head.error;
    assign o_last     = head.last;

endmodule

// ===== test/utf8_to_utf16_transcoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16 transcoder, with a built-in predictor.
module utf8_to_utf16_transcoder_test;

    // Generous cycle budget. The slowest correct run sends about a thousand
    // bytes with random idle gaps, and each of up to two units per byte
    // may wait on a stalling receiver.
    localparam int CYCLE_LIMIT  = 400000;
    // Margin waited out after the last expected unit has arrived.
    localparam int DRAIN_CYCLES = 20;

    // Kinds of damage that the random generator can put into a string.
    typedef enum int {
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_TOO_LARGE,
        FLAW_BAD_LEAD,
        FLAW_BAD_CONT,
        FLAW_TRUNCATED,
        FLAW_STRAY_BYTE
    } t_flaw_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_byte_in;
    logic        i_end_of_string;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_unit_out;
    logic        o_error;
    logic        o_last;

    // Predictor state: one copy of the decoder's sequence state.
    logic [1:0]  cont_left;
    logic [20:0] code_acc;
    logic [1:0]  code_class;
    logic        discarding;

    // UTF-16 units that the block still owes us, oldest first.
    utt_pkg::t_unit expected_units[$];
    // Bytes of the string being built for the next send.
    logic [7:0]  str_bytes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int mismatch_count;
    int cycle_count;
    int bytes_sent;
    int strings_sent;
    int units_checked;
    int bad_strings;

    utf8_to_utf16_transcoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_byte_in       (i_byte_in),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_unit_out      (o_unit_out),
        .o_error         (o_error),
        .o_last          (o_last)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d units still expected", $time, expected_units.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side. A long hold-off requested by a test takes priority over
    // the random stalls, so the block's result queue fills and it must
    // stall its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic push_unit(input logic [15:0] unit, input logic err, input logic lst);
        utt_pkg::t_unit u;
        u.unit  = unit;
        u.error = err;
        u.last  = lst;
        expected_units = {expected_units, u};
    endtask

    task automatic clear_sequence();
        cont_left  = 2'd0;
        code_acc   = '0;
        code_class = utt_pkg::CLASS_NONE;
        discarding = 1'b0;
    endtask

    // An invalid string yields nothing more until its end mark, where a
    // single error unit closes it. If the fault is on the marked byte,
    // that error unit comes right away.
    task automatic flag_bad_string(input logic eos);
        clear_sequence();
        if (eos) begin
            push_unit(16'h0000, 1'b1, 1'b1);
            bad_strings++;
        end else begin
            discarding = 1'b1;
        end
    endtask

    // Code points above the basic plane become a high and a low surrogate;
    // the last flag goes on the final unit only.
    task automatic push_code_point(input logic [20:0] cp, input logic eos);
        logic [19:0] offset;
        if (cp >= utt_pkg::MIN_4B) begin
            offset = 20'(cp - utt_pkg::MIN_4B);
            push_unit(utt_pkg::HIGH_BASE + 16'(offset[19:10]), 1'b0, 1'b0);
            push_unit(utt_pkg::LOW_BASE + 16'(offset[9:0]), 1'b0, eos);
        end else begin
            push_unit(cp[15:0], 1'b0, eos);
        end
    endtask

    task automatic predict_units(input logic [7:0] b, input logic eos);
        logic [20:0] floor_val;
        if (discarding) begin
            if (eos) begin
                clear_sequence();
                push_unit(16'h0000, 1'b1, 1'b1);
                bad_strings++;
            end
            return;
        end
        if (cont_left == 2'd0) begin
            // Lead position.
            if (b[7] == 1'b0) begin
                push_code_point({13'd0, b}, eos);
                if (eos) clear_sequence();
                return;
            end else if (b[7:5] == 3'b110) begin
                cont_left  = 2'd1;
                code_acc   = {16'd0, b[4:0]};
                code_class = utt_pkg::CLASS_2B;
            end else if (b[7:4] == 4'b1110) begin
                cont_left  = 2'd2;
                code_acc   = {17'd0, b[3:0]};
                code_class = utt_pkg::CLASS_3B;
            end else if (b[7:3] == 5'b11110) begin
                cont_left  = 2'd3;
                code_acc   = {18'd0, b[2:0]};
                code_class = utt_pkg::CLASS_4B;
            end else begin
                // A continuation byte or 0xF8..0xFF cannot start a sequence.
                flag_bad_string(eos);
                return;
            end
            // A lead byte carrying the end mark leaves the sequence cut short.
            if (eos) flag_bad_string(eos);
            return;
        end
        if (b[7:6] != 2'b10) begin
            flag_bad_string(eos);
            return;
        end
        code_acc  = {code_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0) begin
            if (eos) flag_bad_string(eos);
            return;
        end
        case (code_class)
            utt_pkg::CLASS_2B: floor_val = utt_pkg::MIN_2B;
            utt_pkg::CLASS_3B: floor_val = utt_pkg::MIN_3B;
            utt_pkg::CLASS_4B: floor_val = utt_pkg::MIN_4B;
            default:           floor_val = '0;
        endcase
        // Overlong forms, surrogate code points and values past the last
        // plane all make the string invalid.
        if (code_acc < floor_val || code_acc > utt_pkg::MAX_CODE ||
            (code_acc >= utt_pkg::SURR_FIRST && code_acc <= utt_pkg::SURR_LAST)) begin
            flag_bad_string(eos);
            return;
        end
        push_code_point(code_acc, eos);
        code_acc   = '0;
        code_class = utt_pkg::CLASS_NONE;
        if (eos) clear_sequence();
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Every accepted result item is matched against the oldest expectation.
    always @(posedge i_clk) begin
        utt_pkg::t_unit want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_units.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected unit: expected none, got unit %h error %b last %b",
                         $time, o_unit_out, o_error, o_last);
            end else begin
                want = expected_units.pop_front();
                check_field("unit_out", want.unit, o_unit_out);
                check_field("error", {15'd0, want.error}, {15'd0, o_error});
                check_field("last", {15'd0, want.last}, {15'd0, o_last});
                units_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one byte, possibly after a random idle gap, and waits for the
    // handshake. Inputs move on the falling edge; acceptance is judged at
    // the rising edge.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_byte_in       <= b;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_units(b, eos);
        bytes_sent++;
    endtask

    // Sends the bytes in str_bytes as one string, end mark on the last one.
    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++) begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
        strings_sent++;
    endtask

    // Adds one byte at the tail of the string being built.
    task automatic add_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    // Appends cp in an n-byte encoding; the length is forced, so overlong
    // and out-of-range forms can be made on purpose.
    task automatic append_utf8(input logic [20:0] cp, input int n);
        case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // A legal code point of a randomly chosen encoded length.
    task automatic append_random_char();
        int pick;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            append_utf8(21'($urandom_range(0, 'h7F)), 1);
        end else if (pick < 55) begin
            append_utf8(21'($urandom_range('h80, 'h7FF)), 2);
        end else if (pick < 80) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= utt_pkg::SURR_FIRST && cp <= utt_pkg::SURR_LAST) cp = cp - 21'h1000;
            append_utf8(cp, 3);
        end else begin
            append_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
        end
    endtask

    task automatic append_flaw();
        t_flaw_kind flaw;
        int n;
        flaw = t_flaw_kind'($urandom_range(0, 6));
        case (flaw)
            FLAW_OVERLONG: begin
                n = $urandom_range(2, 4);
                append_utf8(21'($urandom_range(0, n == 2 ? 'h7F : n == 3 ? 'h7FF : 'hFFFF)), n);
            end
            FLAW_SURROGATE: append_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
            FLAW_TOO_LARGE: append_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            FLAW_BAD_LEAD: begin
                if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range('h80, 'hBF)));
                else add_byte(8'($urandom_range('hF8, 'hFF)));
            end
            FLAW_BAD_CONT: begin
                append_utf8(21'($urandom_range('h10000, 'h10FFFF)), $urandom_range(2, 4));
                // Overwrite one continuation byte with something that is not 10xxxxxx.
                n = $urandom_range(1, str_bytes.size() > 1 ? 1 : 1);
                str_bytes[str_bytes.size() - n] = ($urandom_range(0, 1) == 0) ?
                    8'($urandom_range(0, 'h7F)) : 8'($urandom_range('hC0, 'hFF));
            end
            FLAW_TRUNCATED: begin
                append_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
                n = $urandom_range(1, 3);
                repeat (n) void'(str_bytes.pop_back());
            end
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Mostly well-formed strings with random content; some carry one flaw
    // at a random spot, and a few are plain random bytes.
    task automatic make_random_string();
        int kind;
        int n_chars;
        int flaw_at;
        str_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        n_chars = $urandom_range(1, 6);
        flaw_at = (kind < 30) ? $urandom_range(0, n_chars) : -1;
        for (int i = 0; i <= n_chars; i++) begin
            if (i == flaw_at) append_flaw();
            if (i < n_chars) append_random_char();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Boundary code points of every length, and one string for each kind
    // of invalid input.
    task automatic test_directed_strings();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Smallest value of each of the three shorter lengths: U+0000, U+0080, U+0800.
        str_bytes = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80};
        send_string();
        // Largest value of each of the three shorter lengths.
        str_bytes = '{8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
        send_string();
        // First and last supplementary code points, as surrogate pairs.
        str_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // Overlong two-byte form of U+0000.
        str_bytes = '{8'hC0, 8'h80};
        send_string();
        // Encoded surrogate U+D800.
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string();
        // U+110000 is past the last plane.
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        // Continuation byte in lead position; the rest is dropped.
        str_bytes = '{8'h80, 8'h41};
        send_string();
        // A byte that no UTF-8 sequence can start with, alone in its string.
        str_bytes = '{8'hF8};
        send_string();
        // Lead byte followed by an ASCII byte on the end mark.
        str_bytes = '{8'hC2, 8'h41};
        send_string();
        // Three-byte sequence cut off by the end of the string.
        str_bytes = '{8'hE2, 8'h82};
        send_string();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_bytes);
        int start_count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = bytes_sent;
        while (bytes_sent - start_count < n_bytes) begin
            make_random_string();
            send_string();
        end
    endtask

    // The receiver stops taking results for a long stretch while the sender
    // keeps offering four-byte characters, so the result queue fills and the
    // block has to hold its input.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 80;
        repeat (3) begin
            str_bytes.delete();
            repeat (3) append_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
            send_string();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_byte_in       = 8'h00;
        i_end_of_string = 1'b0;
        i_ready         = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        bytes_sent      = 0;
        strings_sent    = 0;
        units_checked   = 0;
        bad_strings     = 0;
        clear_sequence();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_strings();
        test_random_traffic(0, 0, 215);
        test_random_traffic(74, 0, 215);
        test_random_traffic(0, 74, 215);
        test_random_traffic(13, 13, 215);
        test_output_backpressure();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_units.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected units never arrived", $time, expected_units.size());
        end
        $display("Sent %0d bytes in %0d strings, %0d of them invalid; %0d units checked.",
                 bytes_sent, strings_sent, bad_strings, units_checked);
        $display("Idle and stall mixes, a long receiver hold-off and all error kinds were run.");
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
